// ===== rtl/core/lgs_pkg.sv =====
package lgs_pkg;

  localparam int unsigned COL_COUNT = 64;
  localparam int unsigned CFG_W     = 7;

  // Neighbor counts of the B3/S23 rule.
  localparam logic [3:0] BIRTH_COUNT   = 4'd3;
  localparam logic [3:0] SURVIVE_COUNT = 4'd2;

  // Masked bits that one cell shows to the cells on either side.
  typedef struct packed {
    logic up;     // stored row above the held row
    logic mid;    // held row
    logic row;    // incoming row
    logic above;  // row above the incoming row, dead when no row is held
  } cell_bits_t;

  // Up to two results caused by one input item.
  typedef struct packed {
    logic                 has_held;
    logic [COL_COUNT-1:0] held_row;
    logic                 has_last;
    logic [COL_COUNT-1:0] last_row;
  } result_entry_t;

endpackage

// ===== rtl/core/lgs_cell.sv =====
module lgs_cell
  import lgs_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       en,
  input  logic       holding,
  input  logic       last,
  input  logic       act,
  input  logic       row_bit,
  input  cell_bits_t left,
  input  cell_bits_t right,
  output cell_bits_t own,
  output logic       held_bit,
  output logic       last_bit
);

  logic       upper_r;
  logic       middle_r;
  logic [3:0] held_n;
  logic [3:0] last_n;

  assign own.up    = upper_r & act;
  assign own.mid   = middle_r & act;
  assign own.row   = row_bit & act;
  assign own.above = holding & own.mid;

  assign held_n = 4'(left.up) + 4'(own.up) + 4'(right.up)
                + 4'(left.mid) + 4'(right.mid)
                + 4'(left.row) + 4'(own.row) + 4'(right.row);

  // The bottom row has only dead cells below it.
  assign last_n = 4'(left.above) + 4'(own.above) + 4'(right.above)
                + 4'(left.row) + 4'(right.row);

  assign held_bit = act & ((held_n == BIRTH_COUNT) |
                           ((held_n == SURVIVE_COUNT) & own.mid));
  assign last_bit = act & ((last_n == BIRTH_COUNT) |
                           ((last_n == SURVIVE_COUNT) & own.row));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upper_r  <= 1'b0;
      middle_r <= 1'b0;
    end else if (en) begin
      if (last) begin
        upper_r  <= 1'b0;
        middle_r <= 1'b0;
      end else begin
        upper_r  <= own.above;
        middle_r <= own.row;
      end
    end
  end

endmodule

// ===== rtl/core/lgs_out_queue.sv =====
module lgs_out_queue
  import lgs_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  result_entry_t        push_entry,
  output logic                 push_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [COL_COUNT-1:0] out_next_row,
  output logic                 out_frame_end
);

  result_entry_t ent_r [2];
  logic          wr_ptr_r;
  logic          rd_ptr_r;
  logic [1:0]    count_r;
  logic          sub_r;
  result_entry_t head;
  logic          show_held;
  logic          take;
  logic          pop;

  assign head       = ent_r[rd_ptr_r];
  assign push_ready = (count_r != 2'd2);
  assign out_valid  = (count_r != 2'd0);

  // An entry with two results shows the held row first, then the bottom row.
  assign show_held     = head.has_held & !sub_r;
  assign out_next_row  = show_held ? head.held_row : head.last_row;
  assign out_frame_end = !show_held;

  assign take = out_valid & out_ready;
  assign pop  = take & !(show_held & head.has_last);

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_ptr_r] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
      sub_r    <= 1'b0;
    end else begin
      if (push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= !rd_ptr_r;
        sub_r    <= 1'b0;
      end else if (take) begin
        sub_r <= 1'b1;
      end
      unique case ({push, pop})
        2'b10:   count_r <= count_r + 2'd1;
        2'b01:   count_r <= count_r - 2'd1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

// ===== rtl/core/life_generation_step_core.sv =====
// A row's next generation is computed when the row below it is accepted and is
// pushed to the output queue; a bottom row gives up to two results, offered one
// per cycle while out_ready is high. Throughput: one row per cycle while the output
// queue has room (in_ready high), set by the column cells that update together.
// Reset: synchronous, active low; stored rows dead, no row held, width 64.
module life_generation_step_core
  import lgs_pkg::*;
#(
  parameter int unsigned GRID_WIDTH = 64
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [COL_COUNT-1:0] in_row_cells,
  input  logic                 in_last_row,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [COL_COUNT-1:0] out_next_row,
  output logic                 out_frame_end,
  input  logic                 cfg_wr_en,
  input  logic [CFG_W-1:0]     cfg_wr_data
);

  logic [CFG_W-1:0]     active_width_r;
  logic                 holding_r;
  logic                 accept;
  logic [COL_COUNT-1:0] held_vec;
  logic [COL_COUNT-1:0] last_vec;
  cell_bits_t           nb [GRID_WIDTH+2];
  result_entry_t        entry;

  assign accept = in_valid & in_ready;

  // Dead cells beyond both edges of the grid.
  assign nb[0]            = '0;
  assign nb[GRID_WIDTH+1] = '0;

  for (genvar i = 0; i < COL_COUNT; i++) begin : g_col
    if (i < GRID_WIDTH) begin : g_cell
      logic act;
      assign act = (active_width_r > CFG_W'(i));
      lgs_cell u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (accept),
        .holding  (holding_r),
        .last     (in_last_row),
        .act      (act),
        .row_bit  (in_row_cells[i]),
        .left     (nb[i]),
        .right    (nb[i+2]),
        .own      (nb[i+1]),
        .held_bit (held_vec[i]),
        .last_bit (last_vec[i])
      );
    end else begin : g_dead
      assign held_vec[i] = 1'b0;
      assign last_vec[i] = 1'b0;
    end
  end

  assign entry.has_held = holding_r;
  assign entry.held_row = held_vec;
  assign entry.has_last = in_last_row;
  assign entry.last_row = last_vec;

  lgs_out_queue u_queue (
    .clk           (clk),
    .rst_n         (rst_n),
    .push          (accept & (holding_r | in_last_row)),
    .push_entry    (entry),
    .push_ready    (in_ready),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_next_row  (out_next_row),
    .out_frame_end (out_frame_end)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_width_r <= CFG_W'(64);
      holding_r      <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        active_width_r <= cfg_wr_data;
      end
      if (accept) begin
        holding_r <= !in_last_row;
      end
    end
  end

endmodule

// ===== sim/tb.sv =====
module tb;
  import lgs_pkg::*;

  localparam int unsigned LIMIT_CYCLES = 400000;
  localparam int unsigned PHASE_ROWS   = 90;
  localparam int unsigned PHASE_COUNT  = 10;
  localparam int unsigned HOLD_CYCLES  = 250;
  localparam int unsigned HOLD_AFTER   = 300;

  typedef struct packed {
    logic [COL_COUNT-1:0] cells;
    logic                 frame_end;
  } gen_row_t;

  // Tracks the rows the block holds and the next-generation rows it owes.
  class life_scoreboard;
    gen_row_t             expected_q[$];
    int unsigned          width = 64;
    logic [COL_COUNT-1:0] upper_row = '0;
    logic [COL_COUNT-1:0] middle_row = '0;
    bit                   holding_row = 1'b0;
    int unsigned          errors = 0;

    function logic [COL_COUNT-1:0] col_mask();
      int unsigned w;
      w = (width > COL_COUNT) ? COL_COUNT : width;
      if (w >= COL_COUNT) return '1;
      return (64'd1 << w) - 64'd1;
    endfunction

    function logic [COL_COUNT-1:0] next_generation(input logic [COL_COUNT-1:0] up,
                                                   input logic [COL_COUNT-1:0] mid,
                                                   input logic [COL_COUNT-1:0] down,
                                                   input logic [COL_COUNT-1:0] mask);
      logic [COL_COUNT+1:0] u;
      logic [COL_COUNT+1:0] m;
      logic [COL_COUNT+1:0] d;
      logic [COL_COUNT-1:0] res;
      int                   n;
      // A dead cell is padded on each side, so column i sits at bit i+1.
      u = {1'b0, up & mask, 1'b0};
      m = {1'b0, mid & mask, 1'b0};
      d = {1'b0, down & mask, 1'b0};
      res = '0;
      for (int i = 0; i < COL_COUNT; i++) begin
        n = u[i] + u[i+1] + u[i+2] + m[i] + m[i+2] + d[i] + d[i+1] + d[i+2];
        res[i] = (n == BIRTH_COUNT) || ((n == SURVIVE_COUNT) && m[i+1]);
      end
      return res & mask;
    endfunction

    function void note_row(input logic [COL_COUNT-1:0] cells, input logic last);
      logic [COL_COUNT-1:0] mask;
      logic [COL_COUNT-1:0] row;
      logic [COL_COUNT-1:0] above;
      mask  = col_mask();
      row   = cells & mask;
      above = '0;
      if (holding_row) begin
        expected_q.push_back('{cells: next_generation(upper_row, middle_row, row, mask),
                               frame_end: 1'b0});
        above = middle_row & mask;
      end
      if (last) begin
        expected_q.push_back('{cells: next_generation(above, row, '0, mask),
                               frame_end: 1'b1});
        upper_row   = '0;
        middle_row  = '0;
        holding_row = 1'b0;
      end else begin
        upper_row   = above;
        middle_row  = row;
        holding_row = 1'b1;
      end
    endfunction

    function void check_result(input logic [COL_COUNT-1:0] cells, input logic fe);
      gen_row_t want;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected item next_row=%h frame_end=%b", $time, cells, fe);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      if (cells !== want.cells) begin
        $display("%0t: next_row expected %h, got %h", $time, want.cells, cells);
        errors++;
      end
      if (fe !== want.frame_end) begin
        $display("%0t: frame_end expected %b, got %b", $time, want.frame_end, fe);
        errors++;
      end
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_ready;
  logic [COL_COUNT-1:0] in_row_cells;
  logic                 in_last_row;
  logic                 out_valid;
  logic                 out_ready;
  logic [COL_COUNT-1:0] out_next_row;
  logic                 out_frame_end;
  logic                 cfg_wr_en;
  logic [CFG_W-1:0]     cfg_wr_data;

  life_scoreboard sb = new;
  int unsigned    rows_accepted = 0;
  int unsigned    cycle_count = 0;
  int unsigned    idle_odds = 10;
  bit             hold_done = 1'b0;

  always #5 clk = ~clk;

  life_generation_step_core u_top (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_row_cells (in_row_cells),
    .in_last_row  (in_last_row),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_next_row (out_next_row),
    .out_frame_end(out_frame_end),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data)
  );

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        sb.note_row(in_row_cells, in_last_row);
        rows_accepted++;
      end
      if (out_valid && out_ready) begin
        sb.check_result(out_next_row, out_frame_end);
      end
    end
  end

  initial begin
    wait (cycle_count >= LIMIT_CYCLES);
    $display("Simulation FAILED");
    $finish;
  end

  // Result side: random stalls, plus one long hold so the block backs up.
  // The hold starts only while the sender offers rows without idling.
  initial begin
    out_ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      if (!hold_done && rows_accepted >= HOLD_AFTER && in_valid && idle_odds == 0) begin
        hold_done = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
      end else if (idle_odds != 0 && $urandom_range(0, 99) < idle_odds) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 19) - 1) @(negedge clk);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  function automatic logic [COL_COUNT-1:0] random_row(input logic [COL_COUNT-1:0] prev);
    logic [COL_COUNT-1:0] a;
    logic [COL_COUNT-1:0] b;
    logic [COL_COUNT-1:0] c;
    a = {$urandom, $urandom};
    b = {$urandom, $urandom};
    c = {$urandom, $urandom};
    case ($urandom_range(0, 7))
      0: return a & b & c;
      1: return a | b;
      2: return prev ^ (a & b & c);
      3: return $urandom_range(0, 1) ? '1 : '0;
      4: return {prev[COL_COUNT-2:0], prev[COL_COUNT-1]};
      default: return a;
    endcase
  endfunction

  function automatic int unsigned width_for_phase(input int unsigned p);
    case (p)
      0: return 64;
      1: return 5;
      2: return 0;
      3: return 127;
      4: return 65;
      5: return 1;
      6: return 63;
      7: return 33;
      8: return $urandom_range(0, 127);
      default: return 64;
    endcase
  endfunction

  task automatic send_row(input logic [COL_COUNT-1:0] cells, input logic last);
    if (idle_odds != 0 && $urandom_range(0, 99) < idle_odds) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(negedge clk);
    end
    in_valid     <= 1'b1;
    in_row_cells <= cells;
    in_last_row  <= last;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic send_frame(input int unsigned len);
    logic [COL_COUNT-1:0] cells;
    cells = {$urandom, $urandom};
    for (int unsigned k = 0; k < len; k++) begin
      cells = random_row(cells);
      send_row(cells, k == len - 1);
    end
  endtask

  // The width may only change with no row held and nothing in flight.
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (sb.expected_q.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic set_width(input int unsigned w);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= CFG_W'(w);
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    sb.width = w;
  endtask

  initial begin
    int unsigned sent;
    int unsigned len;
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_row_cells = '0;
    in_last_row  = 1'b0;
    cfg_wr_en    = 1'b0;
    cfg_wr_data  = '0;
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // One-row frames.
    send_row('1, 1'b1);
    send_row('0, 1'b1);
    // Vertical blinker in column 5.
    send_row(64'h20, 1'b0);
    send_row(64'h20, 1'b0);
    send_row(64'h20, 1'b1);
    // Cells on both edge columns.
    send_row(64'h8000_0000_0000_0001, 1'b0);
    send_row(64'h8000_0000_0000_0001, 1'b0);
    send_row(64'h8000_0000_0000_0001, 1'b1);
    send_row('1, 1'b0);
    send_row('1, 1'b1);
    send_row(64'hAAAA_AAAA_AAAA_AAAA, 1'b0);
    send_row(64'h5555_5555_5555_5555, 1'b0);
    send_row(64'hAAAA_AAAA_AAAA_AAAA, 1'b1);
    // Glider.
    send_row(64'h2, 1'b0);
    send_row(64'h4, 1'b0);
    send_row(64'h7, 1'b0);
    send_row('0, 1'b1);
    wait_drained();
    set_width(1);
    send_row('1, 1'b0);
    send_row('1, 1'b0);
    send_row('1, 1'b1);
    wait_drained();
    set_width(0);
    send_row('1, 1'b0);
    send_row('1, 1'b1);
    wait_drained();
    set_width(127);
    send_row('1, 1'b1);

    for (int unsigned p = 0; p < PHASE_COUNT; p++) begin
      wait_drained();
      set_width(width_for_phase(p));
      if (p == PHASE_COUNT - 1) idle_odds = 0;
      else idle_odds = (p % 3 == 0) ? 0 : ((p % 3 == 1) ? 8 : 30);
      sent = 0;
      while (sent < PHASE_ROWS) begin
        case ($urandom_range(0, 9))
          0: len = 1;
          1: len = $urandom_range(10, 24);
          default: len = $urandom_range(2, 6);
        endcase
        send_frame(len);
        sent += len;
      end
    end

    wait_drained();
    repeat (10) @(negedge clk);
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
